// ===== hdl/apt_pkg.sv =====
// Shared package for the arc point evaluator.
// Holds format constants, configuration and pipeline types, and the arctangent table.
// No dependencies.
package apt_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int T_BITS        = 17;
  localparam int T_FRAC_BITS   = 16;
  localparam int COORD_BITS    = 32;
  localparam int RADIUS_BITS   = 31;
  localparam int ANGLE_REG_BITS = 16;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CW            = 32;
  localparam int SHIFT_BITS    = 5;
  localparam int PROD_BITS     = 2 * CW;
  localparam int ROUND_SHIFT   = 30;
  localparam int SUM_BITS      = PROD_BITS - ROUND_SHIFT;

  localparam logic [T_BITS-1:0]      T_ONE           = T_BITS'(65536);
  localparam logic [CW-1:0]          CORDIC_GAIN_Q30 = CW'(652032874);
  localparam logic [COORD_BITS-1:0]  RESET_CENTER    = '0;
  localparam logic [RADIUS_BITS-1:0] RESET_RADIUS    = RADIUS_BITS'(65536);
  localparam logic [ANGLE_REG_BITS-1:0] RESET_START  = '0;
  localparam logic [ANGLE_REG_BITS-1:0] RESET_END    = ANGLE_REG_BITS'(16384);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_ARC_RADIUS  = 3'd2,
    REG_START_ANGLE = 3'd3,
    REG_END_ANGLE   = 3'd4,
    REG_CLOCKWISE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]     center_x;
    logic [COORD_BITS-1:0]     center_y;
    logic [RADIUS_BITS-1:0]    arc_radius;
    logic [ANGLE_REG_BITS-1:0] start_angle;
    logic [ANGLE_REG_BITS-1:0] end_angle;
    logic                      clockwise;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [1:0]    quad;
    logic          err;
  } cell_t;

  // Arctangent of 2^-i in units of 2^32 per full turn.
  function automatic logic [CW-1:0] atan_units(input int unsigned idx);
    logic [CW-1:0] v;
    begin
      unique case (idx)
        0:  v = CW'(536870912);
        1:  v = CW'(316933406);
        2:  v = CW'(167458907);
        3:  v = CW'(85004756);
        4:  v = CW'(42667331);
        5:  v = CW'(21354465);
        6:  v = CW'(10679838);
        7:  v = CW'(5340245);
        8:  v = CW'(2670163);
        9:  v = CW'(1335087);
        10: v = CW'(667544);
        11: v = CW'(333772);
        12: v = CW'(166886);
        13: v = CW'(83443);
        14: v = CW'(41722);
        15: v = CW'(20861);
        16: v = CW'(10430);
        17: v = CW'(5215);
        18: v = CW'(2608);
        19: v = CW'(1304);
        20: v = CW'(652);
        21: v = CW'(326);
        22: v = CW'(163);
        23: v = CW'(81);
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== hdl/apt_angle_front.sv =====
// Front end of the arc point evaluator: range check, span, rounded offset and angle.
// Produces the first CORDIC cell's item. Depends on apt_pkg.
module apt_angle_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  apt_pkg::cfg_t              cfg,
  input  logic                       valid_i,
  input  logic [apt_pkg::T_BITS-1:0] param_t,
  output logic                       valid_o,
  output apt_pkg::cell_t             cell_o
);
  import apt_pkg::*;

  localparam int MUL_BITS = T_BITS + ANGLE_BITS + 1;

  typedef logic [ANGLE_BITS-1:0] ang_t;

  localparam ang_t EIGHTH = ang_t'(1) << (ANGLE_BITS - 3);

  logic [2:0]          v_r, v_nxt;
  logic [T_BITS-1:0]   t_r;
  logic                err1_r, err2_r, err3_r;
  logic [MUL_BITS-1:0] prod_r, prod_nxt;
  ang_t                ang_r, ang_nxt;

  ang_t                sa, ea, span, off, shifted;
  logic [MUL_BITS-1:0] rnd;
  logic signed [ANGLE_BITS-2:0] resid;
  logic [CW-1:0]       z_ext;

  always_comb begin
    sa       = ang_t'(cfg.start_angle);
    ea       = ang_t'(cfg.end_angle);
    span     = cfg.clockwise ? (sa - ea) : (ea - sa);
    prod_nxt = MUL_BITS'(t_r) * MUL_BITS'(span);
    rnd      = prod_r + MUL_BITS'(1 << (T_FRAC_BITS - 1));
    off      = ang_t'(rnd >> T_FRAC_BITS);
    ang_nxt  = cfg.clockwise ? (sa - off) : (sa + off);
    v_nxt    = {v_r[1:0], valid_i};
  end

  always_comb begin
    shifted = ang_r + EIGHTH;
    resid   = $signed({1'b0, shifted[ANGLE_BITS-3:0]}) -
              $signed((ANGLE_BITS-1)'(EIGHTH));
    z_ext   = CW'(resid) << (CW - ANGLE_BITS);
    cell_o.x    = CORDIC_GAIN_Q30;
    cell_o.y    = '0;
    cell_o.z    = z_ext;
    cell_o.quad = shifted[ANGLE_BITS-1:ANGLE_BITS-2];
    cell_o.err  = err3_r;
    valid_o     = v_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= param_t;
    err1_r <= (param_t > T_ONE);
    prod_r <= prod_nxt;
    err2_r <= err1_r;
    ang_r  <= ang_nxt;
    err3_r <= err2_r;
  end

endmodule

// ===== hdl/apt_cordic_cell.sv =====
// One rotation-mode CORDIC cell of the arc point evaluator.
// Performs one micro-rotation per item and registers it for the next cell. Depends on apt_pkg.
module apt_cordic_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           valid_i,
  input  apt_pkg::cell_t                 d_i,
  input  logic [apt_pkg::SHIFT_BITS-1:0] shift_i,
  input  logic [apt_pkg::CW-1:0]         atan_i,
  output logic                           valid_o,
  output apt_pkg::cell_t                 d_o
);
  import apt_pkg::*;

  logic   valid_r, valid_nxt;
  cell_t  d_r, d_nxt;
  logic signed [CW-1:0] dx, dy;

  always_comb begin
    dx        = $signed(d_i.y) >>> shift_i;
    dy        = $signed(d_i.x) >>> shift_i;
    d_nxt     = d_i;
    valid_nxt = valid_i;
    if (!d_i.z[CW-1]) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - atan_i;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + atan_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign valid_o = valid_r;
  assign d_o     = d_r;

endmodule

// ===== hdl/apt_scale_out.sv =====
// Back end of the arc point evaluator: quadrant fold, radius scaling, rounding,
// center offset and saturation. Depends on apt_pkg.
module apt_scale_out (
  input  logic                           clk,
  input  logic                           rst_n,
  input  apt_pkg::cfg_t                  cfg,
  input  logic                           valid_i,
  input  apt_pkg::cell_t                 d_i,
  output logic                           valid_o,
  output logic [apt_pkg::COORD_BITS-1:0] point_x,
  output logic [apt_pkg::COORD_BITS-1:0] point_y,
  output logic                           range_error
);
  import apt_pkg::*;

  logic [2:0] v_r, v_nxt;
  logic       err1_r, err2_r;
  logic signed [PROD_BITS-1:0] px_r, py_r, px_nxt, py_nxt, rndx, rndy;
  logic signed [SUM_BITS-1:0]  rx_r, ry_r;
  logic signed [SUM_BITS-1:0]  sx, sy;
  logic signed [CW-1:0]        c_s, s_s, rad_s;
  logic [COORD_BITS-1:0]       ox_r, oy_r, ox_nxt, oy_nxt;
  logic                        oerr_r;

  function automatic logic [COORD_BITS-1:0] sat(input logic signed [SUM_BITS-1:0] v);
    logic [COORD_BITS-1:0] r;
    begin
      if (v[SUM_BITS-1:COORD_BITS-1] == '0 || v[SUM_BITS-1:COORD_BITS-1] == '1) begin
        r = v[COORD_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
        r = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
        r = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return r;
    end
  endfunction

  always_comb begin
    unique case (d_i.quad)
      2'd0: begin c_s = d_i.x;  s_s = d_i.y;  end
      2'd1: begin c_s = -d_i.y; s_s = d_i.x;  end
      2'd2: begin c_s = -d_i.x; s_s = -d_i.y; end
      2'd3: begin c_s = d_i.y;  s_s = -d_i.x; end
    endcase
    rad_s  = $signed({1'b0, cfg.arc_radius});
    px_nxt = PROD_BITS'(rad_s) * PROD_BITS'(c_s);
    py_nxt = PROD_BITS'(rad_s) * PROD_BITS'(s_s);
    rndx   = px_r + PROD_BITS'(1 << (ROUND_SHIFT - 1));
    rndy   = py_r + PROD_BITS'(1 << (ROUND_SHIFT - 1));
    sx     = SUM_BITS'($signed(cfg.center_x)) + rx_r;
    sy     = SUM_BITS'($signed(cfg.center_y)) + ry_r;
    ox_nxt = err2_r ? cfg.center_x : sat(sx);
    oy_nxt = err2_r ? cfg.center_y : sat(sy);
    v_nxt  = {v_r[1:0], valid_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    err1_r <= d_i.err;
    rx_r   <= rndx[PROD_BITS-1:ROUND_SHIFT];
    ry_r   <= rndy[PROD_BITS-1:ROUND_SHIFT];
    err2_r <= err1_r;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    oerr_r <= err2_r;
  end

  assign valid_o     = v_r[2];
  assign point_x     = ox_r;
  assign point_y     = oy_r;
  assign range_error = oerr_r;

endmodule

// ===== hdl/arc_point_evaluator.sv =====
// Top level of the arc point evaluator: configuration registers and the pipeline.
// Instantiates apt_angle_front, a chain of apt_cordic_cell and apt_scale_out.
// Depends on apt_pkg.
//
// Usage: write the arc's center, radius, start and end angles and direction
// through the cfg_ port while no item is in flight. Present a parameter t on
// in_param_t with start high; busy is always low, so an item is taken at
// every such edge, one per cycle. Each item yields exactly one result, passing
// through three front stages (range check, t times span, angle), one cell per
// CORDIC iteration (16), and three back stages (radius multiply, rounding,
// center add with saturation). The result sits on out_point_x, out_point_y
// and out_range_error for one cycle with out_strobe high. The receiver
// cannot stall; results are produced at the input rate. A t above 1.0 sets
// out_range_error and returns the center. Reset clears all items in flight
// and restores the configuration to a unit quarter arc at the origin.
module arc_point_evaluator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [apt_pkg::T_BITS-1:0]         in_param_t,
  output logic                               out_strobe,
  output logic [apt_pkg::COORD_BITS-1:0]     out_point_x,
  output logic [apt_pkg::COORD_BITS-1:0]     out_point_y,
  output logic                               out_range_error,
  input  logic                               cfg_we,
  input  logic [apt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [apt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import apt_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  accept;
  logic  front_valid;
  cell_t front_cell;
  logic  chain_valid [0:CORDIC_STAGES];
  cell_t chain_d     [0:CORDIC_STAGES];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:    cfg_nxt.center_x    = cfg_wdata[COORD_BITS-1:0];
        REG_CENTER_Y:    cfg_nxt.center_y    = cfg_wdata[COORD_BITS-1:0];
        REG_ARC_RADIUS:  cfg_nxt.arc_radius  = cfg_wdata[RADIUS_BITS-1:0];
        REG_START_ANGLE: cfg_nxt.start_angle = cfg_wdata[ANGLE_REG_BITS-1:0];
        REG_END_ANGLE:   cfg_nxt.end_angle   = cfg_wdata[ANGLE_REG_BITS-1:0];
        REG_CLOCKWISE:   cfg_nxt.clockwise   = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x    <= RESET_CENTER;
      cfg_r.center_y    <= RESET_CENTER;
      cfg_r.arc_radius  <= RESET_RADIUS;
      cfg_r.start_angle <= RESET_START;
      cfg_r.end_angle   <= RESET_END;
      cfg_r.clockwise   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  apt_angle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (accept),
    .param_t (in_param_t),
    .valid_o (front_valid),
    .cell_o  (front_cell)
  );

  assign chain_valid[0] = front_valid;
  assign chain_d[0]     = front_cell;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    apt_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (chain_valid[g]),
      .d_i     (chain_d[g]),
      .shift_i (SHIFT_BITS'(g)),
      .atan_i  (atan_units(g)),
      .valid_o (chain_valid[g+1]),
      .d_o     (chain_d[g+1])
    );
  end

  apt_scale_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .valid_i     (chain_valid[CORDIC_STAGES]),
    .d_i         (chain_d[CORDIC_STAGES]),
    .valid_o     (out_strobe),
    .point_x     (out_point_x),
    .point_y     (out_point_y),
    .range_error (out_range_error)
  );

endmodule

// ===== sim/arc_point_tb_pkg.sv =====
// Scoreboard for the arc point evaluator testbench: arc registers, point prediction
// and the queue of points awaiting comparison.
// Depends on apt_pkg.
package arc_point_tb_pkg;
  import apt_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

  localparam longint CORDIC_START_X = 64'sd652032874;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint ATAN_TURN[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef enum logic [1:0] {QUAD_EAST, QUAD_NORTH, QUAD_WEST, QUAD_SOUTH} quadrant_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  err;
  } arc_point_t;

  function automatic logic [COORD_BITS-1:0] clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
    return COORD_BITS'(v);
  endfunction

  class arc_point_scoreboard;
    logic [COORD_BITS-1:0]     cx;
    logic [COORD_BITS-1:0]     cy;
    logic [RADIUS_BITS-1:0]    radius;
    logic [ANGLE_REG_BITS-1:0] a_start;
    logic [ANGLE_REG_BITS-1:0] a_end;
    logic                      cw;
    arc_point_t                pending_points[$];
    int                        errors;

    function new();
      cx = RESET_CENTER;
      cy = RESET_CENTER;
      radius = RESET_RADIUS;
      a_start = RESET_START;
      a_end = RESET_END;
      cw = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_CENTER_X:    cx = data[COORD_BITS-1:0];
        REG_CENTER_Y:    cy = data[COORD_BITS-1:0];
        REG_ARC_RADIUS:  radius = data[RADIUS_BITS-1:0];
        REG_START_ANGLE: a_start = data[ANGLE_REG_BITS-1:0];
        REG_END_ANGLE:   a_end = data[ANGLE_REG_BITS-1:0];
        REG_CLOCKWISE:   cw = data[0];
        default: ;
      endcase
    endfunction

    function arc_point_t arc_point_at(input logic [T_BITS-1:0] t);
      arc_point_t p;
      logic [ANGLE_BITS-1:0] sa, ea, span, offset, ang, shifted;
      quadrant_t quad;
      longint resid, z, x, y, dx, dy, c, s, r;
      p.err = 1'b0;
      if (t > T_ONE) begin
        p.x = cx;
        p.y = cy;
        p.err = 1'b1;
        return p;
      end
      sa = a_start[ANGLE_BITS-1:0];
      ea = a_end[ANGLE_BITS-1:0];
      span = cw ? sa - ea : ea - sa;
      offset = ANGLE_BITS'((longint'(t) * longint'(span) + 64'sd32768) >>> T_FRAC_BITS);
      ang = cw ? sa - offset : sa + offset;
      shifted = ang + ANGLE_BITS'(1 << (ANGLE_BITS - 3));
      quad = quadrant_t'(shifted[ANGLE_BITS-1 -: 2]);
      resid = longint'(shifted[ANGLE_BITS-3:0]) - (64'sd1 << (ANGLE_BITS - 3));
      z = resid <<< (32 - ANGLE_BITS);
      x = CORDIC_START_X;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_TURN[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_TURN[i];
        end
      end
      case (quad)
        QUAD_EAST:  begin c = x;  s = y;  end
        QUAD_NORTH: begin c = -y; s = x;  end
        QUAD_WEST:  begin c = -x; s = -y; end
        default:    begin c = y;  s = -x; end
      endcase
      r = longint'(radius);
      p.x = clamp_coord(longint'(signed'(cx)) + ((r * c + (64'sd1 << 29)) >>> ROUND_SHIFT));
      p.y = clamp_coord(longint'(signed'(cy)) + ((r * s + (64'sd1 << 29)) >>> ROUND_SHIFT));
      return p;
    endfunction

    function void note_param(input logic [T_BITS-1:0] t);
      pending_points.push_back(arc_point_at(t));
    endfunction

    function int pending();
      return pending_points.size();
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                     input logic err);
      arc_point_t want;
      if (pending_points.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        want = pending_points.pop_front();
        if (x !== want.x)
          report_mismatch($sformatf("point_x %h, expected %h", x, want.x));
        if (y !== want.y)
          report_mismatch($sformatf("point_y %h, expected %h", y, want.y));
        if (err !== want.err)
          report_mismatch($sformatf("range_error %b, expected %b", err, want.err));
      end
    endtask
  endclass

endpackage

// ===== sim/tb_arc_point_evaluator.sv =====
// Testbench top for the arc point evaluator: drives parameters and arc settings with
// random gaps and checks every point against the scoreboard prediction.
// Depends on apt_pkg, arc_point_tb_pkg and the arc_point_evaluator RTL.
module tb_arc_point_evaluator;
  import apt_pkg::*;
  import arc_point_tb_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [T_BITS-1:0]         in_param_t = '0;
  logic                      out_strobe;
  logic [COORD_BITS-1:0]     out_point_x;
  logic [COORD_BITS-1:0]     out_point_y;
  logic                      out_range_error;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  arc_point_scoreboard sb;
  logic                no_gaps = 1'b0;
  int                  quiet_cycles = 0;

  arc_point_evaluator DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_param_t(in_param_t),
    .out_strobe(out_strobe),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y),
    .out_range_error(out_range_error),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (start && !busy) sb.note_param(in_param_t);
      if (out_strobe) sb.check_point(out_point_x, out_point_y, out_range_error);
    end
  end

  always @(posedge clk) begin
    if (cfg_we || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_param(input logic [T_BITS-1:0] t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_param_t <= t;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_arc(input logic [31:0] x, input logic [31:0] y, input logic [31:0] r,
                         input logic [31:0] a0, input logic [31:0] a1,
                         input logic [31:0] dir);
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_ARC_RADIUS, r);
    write_reg(REG_START_ANGLE, a0);
    write_reg(REG_END_ANGLE, a1);
    write_reg(REG_CLOCKWISE, dir);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_points();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [T_BITS-1:0] random_param();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) return T_BITS'($urandom_range(65537, 131071));
    if (pick == 3) return T_ONE;
    if (pick == 4) return '0;
    return T_BITS'($urandom_range(0, 65536));
  endfunction

  function automatic logic [31:0] random_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  initial begin
    logic [31:0] a0, a1, r;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_param('0);
    send_param(T_BITS'(32768));
    send_param(T_ONE);
    send_param(T_BITS'(65537));
    send_param(T_BITS'(131071));
    send_param(T_BITS'(1));
    send_param(T_BITS'(65535));
    send_param(T_BITS'(16384));
    drain_points();

    no_gaps = 1'b1;
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    set_arc(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0, 32'd1);
    send_param('0);
    send_param(T_ONE);
    send_param(T_BITS'(32768));
    send_param(T_BITS'(131071));
    drain_points();

    no_gaps = 1'b0;
    set_arc(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0000_FFFF, 32'd0);
    send_param('0);
    send_param(T_ONE);
    send_param(T_BITS'(21845));
    send_param(T_BITS'(65537));
    drain_points();

    set_arc(32'h0003_8000, 32'hFFFC_0000, 32'd1, 32'h0000_1234, 32'h0000_1234, 32'd0);
    send_param('0);
    send_param(T_ONE);
    send_param(T_BITS'(40000));
    drain_points();

    set_arc(32'h0001_0000, 32'hFFFF_0000, 32'd0, 32'h0000_4000, 32'h0000_C000, 32'd1);
    send_param('0);
    send_param(T_BITS'(30000));
    send_param(T_ONE);
    drain_points();

    for (int phase = 0; phase < 10; phase++) begin
      a0 = $urandom();
      a1 = ($urandom_range(0, 5) == 0) ? a0 : $urandom();
      r = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 32'h0100_0000);
      set_arc(random_coord(), random_coord(), r, a0, a1, $urandom());
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (65) send_param(random_param());
      drain_points();
    end

    repeat (30) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("items left without a result");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
